@@ sv/cfa_pkg.sv @@
// Package for the complex four-operation ALU: operation codes, widths,
// the cell state shared by the cell chain and the top level, and sat16.
// Depends on nothing.
`default_nettype none
package cfa_pkg;
    localparam int DataW    = 16;
    localparam int ProdW    = 33;
    localparam int NumW     = 42;
    localparam int DenW     = 32;
    localparam int QuotW    = 42;
    localparam int DivSteps = 42;
    localparam int BitsPerCell = 2;
    localparam int NumCells = DivSteps / BitsPerCell;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    // Divider state that moves from one cell to the next.
    typedef struct packed {
        logic             valid;
        logic             div_zero;
        logic             is_div;
        logic             re_neg;
        logic             im_neg;
        logic [DenW-1:0]  den;
        logic [NumW-1:0]  re_num;
        logic [NumW-1:0]  im_num;
        logic [NumW:0]    re_rem;
        logic [NumW:0]    im_rem;
        logic [QuotW-1:0] re_q;
        logic [QuotW-1:0] im_q;
    } t_cell;

    // Clamps a wide signed value to 16 bits; bit 16 of the result flags it.
    function automatic logic [DataW:0] sat16(input logic signed [QuotW:0] x);
        logic [DataW:0] r;
        if (x > (QuotW+1)'(signed'(32767))) begin
            r = {1'b1, 16'h7fff};
        end else if (x < -(QuotW+1)'(signed'(32768))) begin
            r = {1'b1, 16'h8000};
        end else begin
            r = {1'b0, x[DataW-1:0]};
        end
        return r;
    endfunction
endpackage
`default_nettype wire

@@ sv/cfa_div_cell.sv @@
// One cell of the restoring divider chain: BitsPerCell quotient bits of
// both parts a cycle while i_en is high. Depends on cfa_pkg.
`default_nettype none
module cfa_div_cell (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_en,
    input  cfa_pkg::t_cell   i_cell,
    output cfa_pkg::t_cell   o_cell
);
    cfa_pkg::t_cell r_cell;
    cfa_pkg::t_cell n_cell;
    logic [cfa_pkg::NumW:0] v_re;
    logic [cfa_pkg::NumW:0] v_im;

    always_comb begin
        n_cell = i_cell;
        v_re = '0;
        v_im = '0;
        // Non-divide requests pass the cell with their result untouched.
        if (i_cell.is_div) begin
            for (int k = 0; k < cfa_pkg::BitsPerCell; k++) begin
                v_re = {n_cell.re_rem[cfa_pkg::NumW-1:0], n_cell.re_num[cfa_pkg::NumW-1]};
                v_im = {n_cell.im_rem[cfa_pkg::NumW-1:0], n_cell.im_num[cfa_pkg::NumW-1]};
                n_cell.re_num = {n_cell.re_num[cfa_pkg::NumW-2:0], 1'b0};
                n_cell.im_num = {n_cell.im_num[cfa_pkg::NumW-2:0], 1'b0};
                if (v_re >= {11'd0, n_cell.den}) begin
                    n_cell.re_rem = v_re - {11'd0, n_cell.den};
                    n_cell.re_q   = {n_cell.re_q[cfa_pkg::QuotW-2:0], 1'b1};
                end else begin
                    n_cell.re_rem = v_re;
                    n_cell.re_q   = {n_cell.re_q[cfa_pkg::QuotW-2:0], 1'b0};
                end
                if (v_im >= {11'd0, n_cell.den}) begin
                    n_cell.im_rem = v_im - {11'd0, n_cell.den};
                    n_cell.im_q   = {n_cell.im_q[cfa_pkg::QuotW-2:0], 1'b1};
                end else begin
                    n_cell.im_rem = v_im;
                    n_cell.im_q   = {n_cell.im_q[cfa_pkg::QuotW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;
endmodule
`default_nettype wire

@@ sv/complex_four_op_alu_top.sv @@
// Top level of the complex four-operation ALU: front-end products, a chain
// of divider cells and the saturating output stage. Depends on cfa_pkg.
//
// Usage: s_axis carries one request per transfer, tdata holds from bit 0
// req_type(2), a_re, a_im, b_re, b_im (16 bits each), padded to 72 bits.
// m_axis returns one result per request, tdata from bit 0 res_re, res_im,
// overflow, div_by_zero, padded to 40 bits.
// Every operation passes 24 register stages: the product register, the
// setup register, 21 divider cells of two quotient bits each, and the
// output register, which the saturating result logic feeds. Add, subtract
// and multiply travel the same chain so results leave in request order.
// One request is accepted per cycle while the receiver does not stall.
// When the receiver stalls the whole pipeline holds; s_axis_tready follows
// m_axis_tready whenever the output register is full. Reset empties the
// pipeline; no results are pending after it.
`default_nettype none
module complex_four_op_alu_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // req_type[1:0], a_re[17:2], a_im[33:18], b_re[49:34], b_im[65:50]
    input  wire  [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // res_re[15:0], res_im[31:16], overflow[32], div_by_zero[33]
    output logic [39:0] m_axis_tdata
);
    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // Stage 1: products.
    logic r1_v;
    logic [1:0] r1_op;
    logic signed [15:0] r1_a, r1_b, r1_c, r1_d;
    logic signed [31:0] r1_ac, r1_bd, r1_bc, r1_ad, r1_cc, r1_dd;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (en) r1_v <= s_axis_tvalid;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_op <= s_axis_tdata[1:0];
            r1_a  <= s_axis_tdata[17:2];
            r1_b  <= s_axis_tdata[33:18];
            r1_c  <= s_axis_tdata[49:34];
            r1_d  <= s_axis_tdata[65:50];
            r1_ac <= $signed(s_axis_tdata[17:2])  * $signed(s_axis_tdata[49:34]);
            r1_bd <= $signed(s_axis_tdata[33:18]) * $signed(s_axis_tdata[65:50]);
            r1_bc <= $signed(s_axis_tdata[33:18]) * $signed(s_axis_tdata[49:34]);
            r1_ad <= $signed(s_axis_tdata[17:2])  * $signed(s_axis_tdata[65:50]);
            r1_cc <= $signed(s_axis_tdata[49:34]) * $signed(s_axis_tdata[49:34]);
            r1_dd <= $signed(s_axis_tdata[65:50]) * $signed(s_axis_tdata[65:50]);
        end
    end

    // Stage 2: set up magnitudes. Non-divide results ride as quotients.
    cfa_pkg::t_cell n_head;
    logic signed [cfa_pkg::ProdW:0] s_re, s_im, m_re, m_im;
    always_comb begin
        n_head = '0;
        n_head.valid  = r1_v;
        n_head.is_div = (r1_op == cfa_pkg::OP_DIV);
        n_head.den    = 32'(r1_cc) + 32'(r1_dd);
        n_head.div_zero = n_head.is_div && (r1_c == 16'sd0) && (r1_d == 16'sd0);
        case (cfa_pkg::t_op'(r1_op))
            cfa_pkg::OP_ADD: begin
                s_re = 34'(r1_a) + 34'(r1_c);
                s_im = 34'(r1_b) + 34'(r1_d);
            end
            cfa_pkg::OP_SUB: begin
                s_re = 34'(r1_a) - 34'(r1_c);
                s_im = 34'(r1_b) - 34'(r1_d);
            end
            cfa_pkg::OP_MUL: begin
                s_re = 34'(r1_ac) - 34'(r1_bd);
                s_im = 34'(r1_bc) + 34'(r1_ad);
            end
            default: begin
                s_re = 34'(r1_ac) + 34'(r1_bd);
                s_im = 34'(r1_bc) - 34'(r1_ad);
            end
        endcase
        n_head.re_neg = s_re[33];
        n_head.im_neg = s_im[33];
        m_re = s_re[33] ? -s_re : s_re;
        m_im = s_im[33] ? -s_im : s_im;
        if (r1_op == cfa_pkg::OP_MUL) begin
            n_head.re_q = 42'(m_re[33:8]);
            n_head.im_q = 42'(m_im[33:8]);
        end else if (n_head.is_div) begin
            n_head.re_num = {m_re[33:0], 8'd0};
            n_head.im_num = {m_im[33:0], 8'd0};
        end else begin
            n_head.re_q = 42'(m_re[33:0]);
            n_head.im_q = 42'(m_im[33:0]);
        end
    end

    cfa_pkg::t_cell r_head;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_head.valid <= 1'b0;
        else if (en) r_head <= n_head;
    end

    cfa_pkg::t_cell chain [cfa_pkg::NumCells+1];
    assign chain[0] = r_head;
    for (genvar g = 0; g < cfa_pkg::NumCells; g++) begin : g_cell
        cfa_div_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_cell(chain[g]), .o_cell(chain[g+1])
        );
    end

    cfa_pkg::t_cell tl;
    assign tl = chain[cfa_pkg::NumCells];
    logic signed [cfa_pkg::QuotW:0] f_re, f_im;
    logic [16:0] q_re, q_im;
    always_comb begin
        f_re = tl.re_neg ? -$signed({1'b0, tl.re_q}) : $signed({1'b0, tl.re_q});
        f_im = tl.im_neg ? -$signed({1'b0, tl.im_q}) : $signed({1'b0, tl.im_q});
        q_re = cfa_pkg::sat16(f_re);
        q_im = cfa_pkg::sat16(f_im);
        if (tl.div_zero) begin
            q_re = '0;
            q_im = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tvalid <= 1'b0;
        else if (en) m_axis_tvalid <= tl.valid;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            m_axis_tdata <= {6'd0, tl.div_zero, q_re[16] | q_im[16],
                             q_im[15:0], q_re[15:0]};
        end
    end

    a_dz_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[33] |-> !m_axis_tdata[32])
        else $error("zero divisor with overflow");
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[33] |-> m_axis_tdata[31:0] == 32'd0)
        else $error("zero divisor with nonzero result");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
endmodule
`default_nettype wire
